// ===== rtl/core/bgcd64_pkg.sv =====
// ----------------------------------------------------------------------------
// bgcd64_pkg: shared types for the binary GCD block
// Operand widths and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bgcd64_pkg;

	localparam int unsigned OPND_W  = 64;
	localparam int unsigned SHIFT_W = 6;   // common power of two, 0..63

	// controller to datapath
	typedef struct packed {
		logic load;    // capture new operands, clear the shift count
		logic step;    // one reduction step
		logic finish;  // write the result register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;    // one of the working values has reached zero
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/bgcd64_dp.sv =====
// ----------------------------------------------------------------------------
// bgcd64_dp: binary GCD datapath
// Working pair, common shift count and result register. One halving or one
// subtract-and-halve step per command.
// ----------------------------------------------------------------------------
`default_nettype none

module bgcd64_dp import bgcd64_pkg::*; (
	input  wire logic              clk,
	input  wire cmd_t              cmd,
	input  wire logic [OPND_W-1:0] operand_a,
	input  wire logic [OPND_W-1:0] operand_b,
	output status_t                status,
	output logic      [OPND_W-1:0] divisor
);

	logic [OPND_W-1:0]  a_q;
	logic [OPND_W-1:0]  b_q;
	logic [SHIFT_W-1:0] k_q;
	logic [OPND_W-1:0]  res_q;

	logic [OPND_W:0]    diff_ab;
	logic [OPND_W-1:0]  diff_ba;
	logic               a_ge_b;

	assign diff_ab = {1'b0, a_q} - {1'b0, b_q};
	assign diff_ba = b_q - a_q;
	assign a_ge_b  = ~diff_ab[OPND_W];

	assign status.done = (a_q == '0) || (b_q == '0);
	assign divisor     = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= operand_a;
			b_q <= operand_b;
			k_q <= '0;
		end else if (cmd.step) begin
			case ({a_q[0], b_q[0]})
				2'b00: begin
					// both even: part of the common power of two
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + SHIFT_W'(1);
				end
				2'b01: begin
					a_q <= a_q >> 1;
				end
				2'b10: begin
					b_q <= b_q >> 1;
				end
				default: begin
					// both odd: the difference is even, halve it at once
					if (a_ge_b) begin
						a_q <= diff_ab[OPND_W:1];
					end else begin
						b_q <= diff_ba >> 1;
					end
				end
			endcase
		end
		if (cmd.finish) begin
			res_q <= (a_q | b_q) << k_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bgcd64_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgcd64_ctrl: binary GCD controller
// Accepts a word, runs the datapath until done, then hands the result to
// the output register when it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bgcd64_ctrl import bgcd64_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_BUSY
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == ST_BUSY) && !status.done;
	assign cmd.finish = (state_q == ST_BUSY) && status.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/binary_gcd_64_top.sv =====
// Steps: one reduction step per cycle while busy; each step removes at
// least one bit from a or b.
// Input: no new word is taken while one is in work; the next word is taken
// as soon as the current result sits in the output register.
// Reset: arst_n clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// binary_gcd_64_top: 64-bit greatest common divisor (binary method)
// Controller plus shift/subtract datapath with a registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_gcd_64_top import bgcd64_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [2*OPND_W-1:0] s_tdata,   // [63:0] operand_a, [127:64] operand_b
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [OPND_W-1:0]   m_tdata    // [63:0] divisor
);

	cmd_t    cmd;
	status_t status;

	// Sequencing: idle -> busy (steps until one value hits zero) -> idle.
	// The finish command waits for a free output register, so a result
	// never overwrites one the sink has not taken.
	bgcd64_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: each cycle halve whichever value is even (both, and count
	// the common factor of two), or replace the larger odd value (a on a tie) by half
	// the difference. A zero operand ends at once and gives a OR b.
	bgcd64_dp u_dp (
		.clk       (clk),
		.cmd       (cmd),
		.operand_a (s_tdata[OPND_W-1:0]),
		.operand_b (s_tdata[2*OPND_W-1:OPND_W]),
		.status    (status),
		.divisor   (m_tdata)
	);

	// a new word starts work, so no second word is taken next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted twice in a row");

	// finish only into a free or draining output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result written over a pending word");

	// a result appears only after the datapath reported completion
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(status.done))
		else $error("result valid without completion");

endmodule

`default_nettype wire
